[hw/rtl/ptf_pkg.sv]
// Shared types, codes and forecast tables of the pressure trend forecaster.
`default_nettype none

package ptf_pkg;

    // Field widths.
    localparam int PRESSURE_W  = 14;
    localparam int MONTH_W     = 4;
    localparam int FORECAST_W  = 5;
    localparam int THRESHOLD_W = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Default history length in half-hour readings (three hours).
    localparam int HISTORY_DEPTH_DEF = 6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_TREND_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_NORTHERN        = 1'b1;

    // Register reset values.
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 8'd16;
    localparam logic                   NORTHERN_RST  = 1'b1;

    // Forecast codes beyond the letters.
    localparam logic [FORECAST_W-1:0] FC_OUT_OF_RANGE  = 5'd26;
    localparam logic [FORECAST_W-1:0] FC_NOT_AVAILABLE = 5'd27;

    // Month masks for the northern hemisphere, bit n is month n.
    localparam logic [15:0] SUMMER_MASK_N = 16'h01C0;
    localparam logic [15:0] WINTER_MASK_N = 16'h1006;

    typedef enum logic [1:0] {
        TR_UNKNOWN = 2'd0,
        TR_RISING  = 2'd1,
        TR_FALLING = 2'd2,
        TR_STEADY  = 2'd3
    } trend_t;

    // Result of the classification of one reading.
    typedef struct packed {
        logic [FORECAST_W-1:0] forecast;
        trend_t                trend;
    } ptf_result_t;

    // Table sizes.
    localparam int RISE_N = 13;
    localparam int FALL_N = 9;
    localparam int STDY_N = 10;
    localparam int IDX_W  = 4;

    // Range limits in tenths of hPa: first and last table entries.
    localparam logic [PRESSURE_W-1:0] RISE_HI = 14'd10300;
    localparam logic [PRESSURE_W-1:0] RISE_LO = 14'd9470;
    localparam logic [PRESSURE_W-1:0] FALL_HI = 14'd10500;
    localparam logic [PRESSURE_W-1:0] FALL_LO = 14'd9850;
    localparam logic [PRESSURE_W-1:0] STDY_HI = 14'd10330;
    localparam logic [PRESSURE_W-1:0] STDY_LO = 14'd9600;

    // Sums of neighboring table entries in tenths of hPa. A reading p is
    // nearer to the later entry exactly when 2p is below the sum, so the
    // nearest index is the count of sums above 2p (ties keep the earlier).
    localparam logic [PRESSURE_W:0] RISE_MID [RISE_N-1] = '{
        15'd20520, 15'd20340, 15'd20190, 15'd20070, 15'd19950, 15'd19850,
        15'd19740, 15'd19620, 15'd19480, 15'd19350, 15'd19240, 15'd19060
    };
    localparam logic [PRESSURE_W:0] FALL_MID [FALL_N-1] = '{
        15'd20900, 15'd20640, 15'd20420, 15'd20280, 15'd20140, 15'd20020,
        15'd19890, 15'd19760
    };
    localparam logic [PRESSURE_W:0] STDY_MID [STDY_N-1] = '{
        15'd20560, 15'd20370, 15'd20220, 15'd20080, 15'd19940, 15'd19830,
        15'd19700, 15'd19550, 15'd19340
    };

    // Letters of each table, 0 is A.
    localparam logic [FORECAST_W-1:0] RISE_LET [RISE_N] = '{
        5'd0, 5'd1, 5'd2, 5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12, 5'd16,
        5'd19, 5'd24, 5'd25
    };
    localparam logic [FORECAST_W-1:0] FALL_LET [FALL_N] = '{
        5'd0, 5'd1, 5'd3, 5'd7, 5'd14, 5'd17, 5'd20, 5'd21, 5'd23
    };
    localparam logic [FORECAST_W-1:0] STDY_LET [STDY_N] = '{
        5'd0, 5'd1, 5'd4, 5'd10, 5'd13, 5'd15, 5'd18, 5'd22, 5'd23, 5'd25
    };

endpackage

`default_nettype wire

[hw/rtl/ptf_if.sv]
// Channel interfaces for readings in and forecasts out.
`default_nettype none

interface ptf_in_if import ptf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [PRESSURE_W-1:0] pressure;
    logic [MONTH_W-1:0]    month;

    modport source (output valid, output pressure, output month, input ready);
    modport sink   (input valid, input pressure, input month, output ready);
endinterface

interface ptf_out_if import ptf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [FORECAST_W-1:0] forecast;
    logic [1:0]            trend;
    logic [PRESSURE_W-1:0] oldest_pressure;

    modport source (output valid, output forecast, output trend, output oldest_pressure,
                    input ready);
    modport sink   (input valid, input forecast, input trend, input oldest_pressure,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/pressure_trend_forecaster.sv]
// Pressure trend forecaster: reading in, lettered forecast out.
//
// One reading beat enters on in_ch (pressure in tenths of hPa and month)
// and produces exactly one forecast beat on out_ch (forecast letter code,
// trend and the oldest reading of the history). Each accepted reading is
// shifted into the history at the accept edge and captured in an input
// register; the classification and table lookup are combinational from
// the input register into the result register. A forecast is offered on
// out_ch once the result register takes it from the input register when
// out_ch is free, and a new reading can be accepted every cycle while it is.
// The input register and the result register form a two-deep pipeline, so
// when out_ch stalls the block still takes one more reading and then holds
// ready low until the result is taken; nothing is dropped or repeated.
// Configuration writes (threshold, hemisphere) take effect at once and are
// meant to be done while no reading is in flight. Reset clears the history
// to no readings, the held trend to unknown, both registers to their
// defaults and empties the pipeline.
`default_nettype none

module pressure_trend_forecaster import ptf_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    ptf_in_if.sink                      in_ch,
    ptf_out_if.source                   out_ch,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [THRESHOLD_W-1:0] threshold_reg;
    logic                   northern_reg;
    trend_t                 last_trend_reg;

    logic                   s1_valid_reg;
    logic [PRESSURE_W-1:0]  s1_pressure_reg;
    logic [MONTH_W-1:0]     s1_month_reg;
    logic [PRESSURE_W-1:0]  s1_oldest_reg;

    logic                   out_valid_reg;
    ptf_result_t            out_result_reg;
    logic [PRESSURE_W-1:0]  out_oldest_reg;

    logic                   in_beat;
    logic                   s1_advance;
    logic                   out_free;
    logic [PRESSURE_W-1:0]  hist_oldest;
    ptf_result_t            s1_result;

    // Pipeline flow control.
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_advance  = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_beat     = in_ch.valid && in_ch.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            northern_reg  <= NORTHERN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TREND_THRESHOLD: threshold_reg <= cfg_data[THRESHOLD_W-1:0];
                REG_NORTHERN:        northern_reg  <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    ptf_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_beat),
        .pressure (in_ch.pressure),
        .oldest   (hist_oldest)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_pressure_reg <= in_ch.pressure;
            s1_month_reg    <= in_ch.month;
            s1_oldest_reg   <= hist_oldest;
        end
    end

    ptf_classify u_classify (
        .pressure   (s1_pressure_reg),
        .month      (s1_month_reg),
        .oldest     (s1_oldest_reg),
        .threshold  (threshold_reg),
        .northern   (northern_reg),
        .last_trend (last_trend_reg),
        .result     (s1_result)
    );

    // Held trend and result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_trend_reg <= TR_UNKNOWN;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                last_trend_reg <= s1_result.trend;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_result_reg <= s1_result;
            out_oldest_reg <= s1_oldest_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.forecast        = out_result_reg.forecast;
    assign out_ch.trend           = out_result_reg.trend;
    assign out_ch.oldest_pressure = out_oldest_reg;

    // A forecast letter or out-of-range code needs a filled history.
    a_forecast_needs_history: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.forecast != FC_NOT_AVAILABLE
        |-> out_oldest_reg != '0)
        else $error("forecast given with an empty oldest entry");

    // An unknown trend can only come with no forecast.
    a_unknown_trend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.trend == TR_UNKNOWN
        |-> out_result_reg.forecast == FC_NOT_AVAILABLE)
        else $error("unknown trend with a forecast");

    // Forecast codes never exceed the not-available code.
    a_forecast_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_result_reg.forecast <= FC_NOT_AVAILABLE)
        else $error("forecast code out of range");

    // An accepted reading is in the input register in the next cycle.
    a_beat_captured: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> s1_valid_reg)
        else $error("accepted reading lost");

endmodule

`default_nettype wire

[hw/rtl/ptf_history.sv]
// Shift register of past pressure readings.
`default_nettype none

module ptf_history import ptf_pkg::*; #(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  shift_en,
    input  wire logic [PRESSURE_W-1:0] pressure,
    output logic      [PRESSURE_W-1:0] oldest
);

    logic [PRESSURE_W-1:0] hist_reg  [HISTORY_DEPTH];
    logic [PRESSURE_W-1:0] hist_next [HISTORY_DEPTH];

    // Entry 0 is the oldest; a new reading enters at the top.
    always_comb
    begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++)
        begin
            hist_next[i] = hist_reg[i+1];
        end
        hist_next[HISTORY_DEPTH-1] = pressure;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            hist_reg <= hist_next;
        end
    end

    // The entry that becomes the oldest once this beat is shifted in.
    assign oldest = hist_next[0];

endmodule

`default_nettype wire

[hw/rtl/ptf_classify.sv]
// Trend classification and nearest-entry table lookup for one reading.
`default_nettype none

module ptf_classify import ptf_pkg::*; (
    input  wire logic [PRESSURE_W-1:0]  pressure,
    input  wire logic [MONTH_W-1:0]     month,
    input  wire logic [PRESSURE_W-1:0]  oldest,
    input  wire logic [THRESHOLD_W-1:0] threshold,
    input  wire logic                   northern,
    input  wire trend_t                 last_trend,
    output ptf_result_t                 result
);

    logic signed [PRESSURE_W:0] diff;
    logic signed [PRESSURE_W:0] thr;
    logic                       rising;
    logic                       falling;
    logic                       summer;
    logic                       winter;
    logic [PRESSURE_W:0]        p2;
    logic [IDX_W-1:0]           rise_idx;
    logic [IDX_W-1:0]           fall_idx;
    logic [IDX_W-1:0]           stdy_idx;
    logic [IDX_W-1:0]           rise_adj;
    logic [IDX_W-1:0]           fall_adj;
    logic                       rise_in;
    logic                       fall_in;
    logic                       stdy_in;

    // Trend over the history span.
    assign diff    = $signed({1'b0, pressure}) - $signed({1'b0, oldest});
    assign thr     = $signed({{(PRESSURE_W + 1 - THRESHOLD_W){1'b0}}, threshold});
    assign rising  = (diff >= thr);
    assign falling = (diff <= -thr);

    // Seasons swap between the hemispheres.
    assign summer = northern ? SUMMER_MASK_N[month] : WINTER_MASK_N[month];
    assign winter = northern ? WINTER_MASK_N[month] : SUMMER_MASK_N[month];

    // Nearest table entry. The midpoints fall along each table, so the ones
    // above the reading form a prefix and the last of them gives the index.
    assign p2 = {pressure, 1'b0};

    always_comb
    begin
        rise_idx = '0;
        fall_idx = '0;
        stdy_idx = '0;
        for (int k = 0; k < RISE_N - 1; k++)
        begin
            if (p2 < RISE_MID[k])
            begin
                rise_idx = IDX_W'(k + 1);
            end
        end
        for (int k = 0; k < FALL_N - 1; k++)
        begin
            if (p2 < FALL_MID[k])
            begin
                fall_idx = IDX_W'(k + 1);
            end
        end
        for (int k = 0; k < STDY_N - 1; k++)
        begin
            if (p2 < STDY_MID[k])
            begin
                stdy_idx = IDX_W'(k + 1);
            end
        end
    end

    // Seasonal step, held at the table edges.
    assign rise_adj = (summer && rise_idx != IDX_W'(RISE_N - 1)) ? rise_idx + 1'b1 : rise_idx;
    assign fall_adj = (winter && fall_idx != '0) ? fall_idx - 1'b1 : fall_idx;

    assign rise_in = (pressure <= RISE_HI) && (pressure >= RISE_LO);
    assign fall_in = (pressure <= FALL_HI) && (pressure >= FALL_LO);
    assign stdy_in = (pressure <= STDY_HI) && (pressure >= STDY_LO);

    // Select the table by trend; an empty oldest entry means no forecast.
    always_comb
    begin
        if (oldest == '0)
        begin
            result.forecast = FC_NOT_AVAILABLE;
            result.trend    = last_trend;
        end
        else if (rising)
        begin
            result.forecast = rise_in ? RISE_LET[rise_adj] : FC_OUT_OF_RANGE;
            result.trend    = TR_RISING;
        end
        else if (falling)
        begin
            result.forecast = fall_in ? FALL_LET[fall_adj] : FC_OUT_OF_RANGE;
            result.trend    = TR_FALLING;
        end
        else
        begin
            result.forecast = stdy_in ? STDY_LET[stdy_idx] : FC_OUT_OF_RANGE;
            result.trend    = TR_STEADY;
        end
    end

endmodule

`default_nettype wire
